// ===== hdl/ssh_pkg.sv =====
// shared types, constants and helpers of the space-saving heavy-hitter table
`default_nettype none
package ssh_pkg;

  // table geometry and field widths
  localparam int TABLE_SLOTS = 32;
  localparam int COUNT_BITS  = 32;
  localparam int KEY_W       = 64;
  localparam int THR_W       = 32;
  localparam int OUT_W       = 32;
  localparam int CAP_W       = 6;
  localparam int IDX_W       = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int PTR_W       = $clog2(TABLE_SLOTS + 1);
  localparam int CMP_W       = (COUNT_BITS > THR_W) ? COUNT_BITS : THR_W;

  typedef logic [COUNT_BITS-1:0] count_t;

  localparam count_t COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [PTR_W-1:0] CAP_RESET =
    PTR_W'((TABLE_SLOTS < 32) ? TABLE_SLOTS : 32);

  // request codes
  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_REPORT = 1'b1;

  // one table entry
  typedef struct packed {
    logic [KEY_W-1:0] key;
    count_t           count;
    count_t           err;
  } slot_t;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_UPD  = 4'b0100,
    ST_REP  = 4'b1000
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic scan;
    logic upd_wr;
    logic rep_end;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic out_free;
    logic is_report;
  } ctrl_sts_t;

  // saturating increment of a count
  function automatic count_t sat_inc(count_t v);
    return (v == COUNT_MAX) ? v : v + count_t'(1);
  endfunction

  // capacity write clamped to 1..TABLE_SLOTS
  function automatic logic [PTR_W-1:0] clamp_cap(logic [CAP_W-1:0] v);
    logic [PTR_W-1:0] r;
    if (v == '0) begin
      r = PTR_W'(1);
    end else if (int'(v) > TABLE_SLOTS) begin
      r = PTR_W'(TABLE_SLOTS);
    end else begin
      r = PTR_W'(v);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/ssh_ctrl.sv =====
// sequencing state machine of the heavy-hitter table
`default_nettype none
module ssh_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ssh_pkg::ctrl_sts_t sts_i,
  output ssh_pkg::ctrl_cmd_t cmd_o
);
  import ssh_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts_i.scan_done) state_d = sts_i.is_report ? ST_REP : ST_UPD;
      end
      ST_UPD: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      ST_REP: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // commands
  assign in_ready_o    = (state_q == ST_IDLE);
  assign cmd_o.start   = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.scan    = (state_q == ST_SCAN);
  assign cmd_o.upd_wr  = (state_q == ST_UPD) && sts_i.out_free;
  assign cmd_o.rep_end = (state_q == ST_REP) && sts_i.out_free;

endmodule
`default_nettype wire

// ===== hdl/ssh_dpath.sv =====
// slot memory, scan pipeline, update logic and output register
`default_nettype none
module ssh_dpath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [ssh_pkg::CAP_W-1:0] cfg_wdata_i,
  input  logic                      req_type_i,
  input  logic [ssh_pkg::KEY_W-1:0] key_i,
  input  logic [ssh_pkg::THR_W-1:0] threshold_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [ssh_pkg::KEY_W-1:0] item_key_o,
  output logic [ssh_pkg::OUT_W-1:0] item_count_o,
  output logic [ssh_pkg::OUT_W-1:0] item_error_o,
  output logic                      none_found_o,
  output logic                      last_o,
  input  ssh_pkg::ctrl_cmd_t        cmd_i,
  output ssh_pkg::ctrl_sts_t        sts_o
);
  import ssh_pkg::*;

  slot_t            mem_q [TABLE_SLOTS];
  slot_t            rd_data_q;
  logic [PTR_W-1:0] cap_q, filled_q, cap_new;
  logic             req_q;
  logic [KEY_W-1:0] key_q;
  logic [THR_W-1:0] thr_q;
  logic [PTR_W-1:0] ptr_q;
  logic             ev_valid_q;
  logic [IDX_W-1:0] ev_idx_q;
  logic             found_q;
  logic [IDX_W-1:0] hit_idx_q, min_idx_q;
  count_t           hit_cnt_q, hit_err_q, min_cnt_q;
  logic             pend_valid_q;
  slot_t            pend_q;
  logic             out_valid_q, out_none_q, out_last_q;
  slot_t            out_q;

  logic             out_free, issue_done, key_hit, thr_hit, stall;
  logic             advance, rd_en, ev_fire, push, fill_new;
  logic [IDX_W-1:0] wr_idx;
  slot_t            wr_slot;
  logic             out_load, out_none_d, out_last_d;
  slot_t            out_d;

  // scan status
  assign out_free   = !out_valid_q || out_ready_i;
  assign issue_done = (ptr_q == filled_q);
  assign key_hit    = (rd_data_q.key == key_q);
  assign thr_hit    = (CMP_W'(rd_data_q.count) >= CMP_W'(thr_q));
  assign push       = (req_q == REQ_REPORT) && ev_valid_q && thr_hit && pend_valid_q;
  assign stall      = push && !out_free;
  assign advance    = cmd_i.scan && !stall;
  assign rd_en      = advance && !issue_done;
  assign ev_fire    = cmd_i.scan && ev_valid_q && !stall;

  assign sts_o.scan_done = issue_done && !ev_valid_q;
  assign sts_o.out_free  = out_free;
  assign sts_o.is_report = (req_q == REQ_REPORT);

  // slot memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.upd_wr) mem_q[wr_idx] <= wr_slot;
    if (rd_en) rd_data_q <= mem_q[ptr_q[IDX_W-1:0]];
  end

  // update write: hit, fill a free slot, or take over the minimum
  always_comb begin
    fill_new = 1'b0;
    if (found_q) begin
      wr_idx  = hit_idx_q;
      wr_slot = '{key: key_q, count: sat_inc(hit_cnt_q), err: hit_err_q};
    end else if (filled_q < cap_q) begin
      fill_new = 1'b1;
      wr_idx   = filled_q[IDX_W-1:0];
      wr_slot  = '{key: key_q, count: count_t'(1), err: '0};
    end else begin
      wr_idx  = min_idx_q;
      wr_slot = '{key: key_q, count: sat_inc(min_cnt_q), err: min_cnt_q};
    end
  end

  // capacity and fill count
  assign cap_new = clamp_cap(cfg_wdata_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q    <= CAP_RESET;
      filled_q <= '0;
    end else if (cfg_we_i) begin
      cap_q <= cap_new;
      if (filled_q > cap_new) filled_q <= cap_new;
    end else if (cmd_i.upd_wr && fill_new) begin
      filled_q <= filled_q + PTR_W'(1);
    end
  end

  // request latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      req_q <= req_type_i;
      key_q <= key_i;
      thr_q <= threshold_i;
    end
  end

  // scan pointer and evaluate stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q        <= '0;
      ev_valid_q   <= 1'b0;
      found_q      <= 1'b0;
      pend_valid_q <= 1'b0;
    end else if (cmd_i.start) begin
      ptr_q        <= '0;
      ev_valid_q   <= 1'b0;
      found_q      <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        ev_valid_q <= !issue_done;
        if (!issue_done) ptr_q <= ptr_q + PTR_W'(1);
      end
      if (ev_fire && (req_q == REQ_UPDATE) && key_hit) found_q <= 1'b1;
      if (ev_fire && (req_q == REQ_REPORT) && thr_hit) pend_valid_q <= 1'b1;
    end
  end

  // evaluate stage payload: first hit, running minimum, pending match
  always_ff @(posedge clk_i) begin
    if (advance) ev_idx_q <= ptr_q[IDX_W-1:0];
    if (ev_fire) begin
      if (key_hit && !found_q) begin
        hit_idx_q <= ev_idx_q;
        hit_cnt_q <= rd_data_q.count;
        hit_err_q <= rd_data_q.err;
      end
      if ((ev_idx_q == '0) || (rd_data_q.count < min_cnt_q)) begin
        min_idx_q <= ev_idx_q;
        min_cnt_q <= rd_data_q.count;
      end
      if (thr_hit) pend_q <= rd_data_q;
    end
  end

  // output word select
  always_comb begin
    out_load   = 1'b0;
    out_d      = pend_q;
    out_none_d = 1'b0;
    out_last_d = 1'b0;
    if (cmd_i.upd_wr) begin
      out_load   = 1'b1;
      out_d      = wr_slot;
      out_last_d = 1'b1;
    end else if (cmd_i.rep_end) begin
      out_load   = 1'b1;
      out_last_d = 1'b1;
      if (!pend_valid_q) begin
        out_d      = '0;
        out_none_d = 1'b1;
      end
    end else if (ev_fire && push) begin
      out_load = 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_load || (out_valid_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q      <= out_d;
      out_none_q <= out_none_d;
      out_last_q <= out_last_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign item_key_o   = out_q.key;
  assign item_count_o = OUT_W'(out_q.count);
  assign item_error_o = OUT_W'(out_q.err);
  assign none_found_o = out_none_q;
  assign last_o       = out_last_q;

endmodule
`default_nettype wire

// ===== hdl/space_saving_heavy_hitters.sv =====
// space-saving heavy-hitter table, top level
// scan: a request scans the N filled slots one per cycle (unless a report stalls on a
//   held output word) through the registered slot memory read; then an update's word
//   is loaded into the output register; one request at a time, and any request
//   also waits while the consumer holds back an earlier word
// reset: capacity returns to 32 and the table is empty; slot contents are not cleared
`default_nettype none
module space_saving_heavy_hitters (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [ssh_pkg::CAP_W-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      req_type_i,
  input  logic [ssh_pkg::KEY_W-1:0] key_i,
  input  logic [ssh_pkg::THR_W-1:0] threshold_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [ssh_pkg::KEY_W-1:0] item_key_o,
  output logic [ssh_pkg::OUT_W-1:0] item_count_o,
  output logic [ssh_pkg::OUT_W-1:0] item_error_o,
  output logic                      none_found_o,
  output logic                      last_o
);
  import ssh_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // sequencer
  ssh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // table datapath
  ssh_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req_type_i   (req_type_i),
    .key_i        (key_i),
    .threshold_i  (threshold_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .item_key_o   (item_key_o),
    .item_count_o (item_count_o),
    .item_error_o (item_error_o),
    .none_found_o (none_found_o),
    .last_o       (last_o),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// testbench of the space-saving heavy-hitter table
`timescale 1ns / 100ps
module testbench;

  import ssh_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int SETTLE_TICKS = 40;
  localparam int POOL_MAX     = 64;

  // one output word as the checker sees it
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [OUT_W-1:0] count;
    logic [OUT_W-1:0] err;
    logic             none;
    logic             last;
  } word_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [CAP_W-1:0] cfg_wdata_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic             req_type_i = REQ_UPDATE;
  logic [KEY_W-1:0] key_i = '0;
  logic [THR_W-1:0] threshold_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [KEY_W-1:0] item_key_o;
  logic [OUT_W-1:0] item_count_o;
  logic [OUT_W-1:0] item_error_o;
  logic             none_found_o;
  logic             last_o;

  // predicted table contents and words still owed by the block
  logic [KEY_W-1:0] tally_key [TABLE_SLOTS];
  count_t           tally_count [TABLE_SLOTS];
  count_t           tally_err [TABLE_SLOTS];
  int               tally_filled = 0;
  int               tally_cap = TABLE_SLOTS;
  word_t            pending_words[$];

  logic [KEY_W-1:0] key_pool [POOL_MAX];
  int send_idle_pct = 38;
  int recv_idle_pct = 85;
  int error_count = 0;
  int cycle_count = 0;

  space_saving_heavy_hitters dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .key_i        (key_i),
    .threshold_i  (threshold_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .item_key_o   (item_key_o),
    .item_count_o (item_count_o),
    .item_error_o (item_error_o),
    .none_found_o (none_found_o),
    .last_o       (last_o)
  );

  always #2 clk_i = ~clk_i;

  // consumer back-pressure
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // run watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic count_t bump_count(count_t c);
    return (&c) ? c : c + count_t'(1);
  endfunction

  // count one occurrence and predict the single word it yields
  task automatic tally_update(logic [KEY_W-1:0] k);
    int hit;
    int i;
    word_t w;
    hit = -1;
    for (i = 0; i < tally_filled; i++) begin
      if (hit < 0 && tally_key[i] == k) hit = i;
    end
    if (hit >= 0) begin
      tally_count[hit] = bump_count(tally_count[hit]);
    end else if (tally_filled < tally_cap) begin
      hit = tally_filled;
      tally_key[hit] = k;
      tally_count[hit] = count_t'(1);
      tally_err[hit] = '0;
      tally_filled++;
    end else begin
      // take over the lowest-indexed slot holding the minimum count
      hit = 0;
      for (i = 1; i < tally_filled; i++) begin
        if (tally_count[i] < tally_count[hit]) hit = i;
      end
      tally_key[hit] = k;
      tally_err[hit] = tally_count[hit];
      tally_count[hit] = bump_count(tally_count[hit]);
    end
    w.key = tally_key[hit];
    w.count = OUT_W'(tally_count[hit]);
    w.err = OUT_W'(tally_err[hit]);
    w.none = 1'b0;
    w.last = 1'b1;
    pending_words.push_back(w);
  endtask

  // predict the words of a report, in slot order
  task automatic tally_report(logic [THR_W-1:0] thr);
    word_t hits[$];
    word_t w;
    int i;
    for (i = 0; i < tally_filled; i++) begin
      if (tally_count[i] >= thr) begin
        w.key = tally_key[i];
        w.count = OUT_W'(tally_count[i]);
        w.err = OUT_W'(tally_err[i]);
        w.none = 1'b0;
        w.last = 1'b0;
        hits.push_back(w);
      end
    end
    if (hits.size() == 0) begin
      w = '0;
      w.none = 1'b1;
      w.last = 1'b1;
      pending_words.push_back(w);
    end else begin
      w = hits.pop_back();
      w.last = 1'b1;
      hits.push_back(w);
      foreach (hits[j]) pending_words.push_back(hits[j]);
    end
  endtask

  // present one request word and hold it until accepted
  task automatic send_word(logic req, logic [KEY_W-1:0] k, logic [THR_W-1:0] thr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    key_i <= k;
    threshold_i <= thr;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (req == REQ_REPORT) tally_report(thr);
    else tally_update(k);
    @(negedge clk_i);
  endtask

  // stop sending and wait for every owed word
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_words.size() != 0) @(negedge clk_i);
  endtask

  // capacity write while the block is idle
  task automatic set_capacity(logic [CAP_W-1:0] v);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (v == '0) tally_cap = 1;
    else if (int'(v) > TABLE_SLOTS) tally_cap = TABLE_SLOTS;
    else tally_cap = int'(v);
    if (tally_filled > tally_cap) tally_filled = tally_cap;
  endtask

  task automatic check_field(string name, logic [KEY_W-1:0] want, logic [KEY_W-1:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // compare every accepted output word with the oldest prediction
  always @(posedge clk_i) begin : check_words
    word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_words.size() == 0) begin
        error_count++;
        $display("%0t: unexpected word, expected none, actual key %h count %h",
                 $time, item_key_o, item_count_o);
      end else begin
        want = pending_words.pop_front();
        check_field("item_key", want.key, item_key_o);
        check_field("item_count", KEY_W'(want.count), KEY_W'(item_count_o));
        check_field("item_error", KEY_W'(want.err), KEY_W'(item_error_o));
        check_field("none_found", KEY_W'(want.none), KEY_W'(none_found_o));
        check_field("last", KEY_W'(want.last), KEY_W'(last_o));
      end
    end
  end

  // empty table, extreme keys and thresholds, evictions, capacity clamps
  task automatic test_directed();
    send_word(REQ_REPORT, '0, '0);
    send_word(REQ_UPDATE, '0, '0);
    send_word(REQ_UPDATE, '1, '0);
    send_word(REQ_UPDATE, '0, '0);
    send_word(REQ_UPDATE, 64'hA5A5_A5A5_A5A5_A5A5, '1);
    send_word(REQ_REPORT, '1, '0);
    send_word(REQ_REPORT, '0, '1);
    send_word(REQ_REPORT, '0, 32'd2);
    // table full at three slots: tie on the minimum goes to the lowest slot
    set_capacity(CAP_W'(3));
    send_word(REQ_UPDATE, 64'h5A5A_5A5A_5A5A_5A5A, '0);
    send_word(REQ_REPORT, '0, 32'd1);
    // zero capacity acts as one slot and drops the rest
    set_capacity('0);
    send_word(REQ_UPDATE, 64'h1, '0);
    send_word(REQ_UPDATE, 64'h1, '0);
    send_word(REQ_REPORT, '0, 32'd4);
    // oversize capacity clamps to the full table
    set_capacity('1);
    send_word(REQ_UPDATE, 64'h2, '0);
    send_word(REQ_UPDATE, 64'h3, '0);
    send_word(REQ_REPORT, '0, '0);
  endtask

  // skewed key stream with noise keys and reports mixed in
  task automatic run_stream(int items, int pool_n);
    int n;
    int r;
    int sel;
    logic [KEY_W-1:0] k;
    logic [THR_W-1:0] thr;
    for (n = 0; n < pool_n; n++) key_pool[n] = {$urandom, $urandom};
    for (n = 0; n < items; n++) begin
      if (n == items / 2) wait_drained();
      r = $urandom_range(99);
      if (r < 85) begin
        k = key_pool[$urandom_range(0, $urandom_range(0, pool_n - 1))];
        send_word(REQ_UPDATE, k, {$urandom});
      end else if (r < 90) begin
        send_word(REQ_UPDATE, {$urandom, $urandom}, {$urandom});
      end else begin
        sel = $urandom_range(3);
        if (sel == 0) thr = '0;
        else if (sel == 3) thr = $urandom;
        else thr = THR_W'($urandom_range(0, 10));
        send_word(REQ_REPORT, {$urandom, $urandom}, thr);
      end
    end
  endtask

  task automatic test_slow_sink();
    set_capacity(CAP_W'(TABLE_SLOTS));
    send_idle_pct = 38;
    recv_idle_pct = 85;
    run_stream(90, 40);
  endtask

  task automatic test_slow_source();
    set_capacity(CAP_W'(5));
    send_idle_pct = 85;
    recv_idle_pct = 38;
    run_stream(90, 12);
  endtask

  task automatic test_full_rate();
    set_capacity(CAP_W'($urandom_range(0, 63)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_stream(45, 24);
    set_capacity(CAP_W'(1));
    run_stream(45, 6);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_slow_sink();
    test_slow_source();
    test_full_rate();
    wait_drained();
    repeat (SETTLE_TICKS) @(negedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
